[rtl/core/utf8_stream_decoder_unit_defines.svh]
// Assertion macros used by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define UTF8D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A word offered and not taken keeps the given signal steady into the next cycle.
`define UTF8D_ASSERT_STALL_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
	`UTF8D_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

[rtl/core/utf8d_pkg.sv]
// Types and constants shared by the UTF-8 stream decoder modules.
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W      = 21;
	localparam int COUNT_W   = 3;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CP_W-1:0] FLOOR_LEN2    = 21'h00007F;
	localparam logic [CP_W-1:0] FLOOR_LEN3    = 21'h0007FF;
	localparam logic [CP_W-1:0] FLOOR_LEN4    = 21'h00FFFF;
	localparam logic [CP_W-1:0] SURROGATE_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] SURROGATE_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] MAX_SCALAR    = 21'h10FFFF;

	localparam logic [7:0] ASCII_MAX   = 8'h7F;
	localparam logic [7:0] LEAD2_MIN   = 8'hC0;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD_LIMIT  = 8'hF8;
	localparam logic [1:0] CONT_TAG    = 2'b10;

	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic               is_error;
		logic [COUNT_W-1:0] byte_count;
		logic               last_of_run;
	} utf8d_result_t;

	typedef struct packed {
		logic [CP_W-1:0] accumulated_bits;
		logic [1:0]      bytes_still_expected;
		logic [1:0]      bytes_taken;
		logic [2:0]      sequence_length;
	} utf8d_state_t;

endpackage

[rtl/core/utf8d_decode.sv]
// Combinational step of the decoder: one byte and the open sequence give results and new state.
`timescale 1ns / 1ps

module utf8d_decode (
	input  logic [7:0]              data_byte,
	input  logic                    end_of_data,
	input  utf8d_pkg::utf8d_state_t state_cur,
	output utf8d_pkg::utf8d_state_t state_nxt,
	output utf8d_pkg::utf8d_result_t res0,
	output utf8d_pkg::utf8d_result_t res1,
	output logic [1:0]              res_cnt
);
	import utf8d_pkg::*;

	utf8d_result_t   lead_res;
	utf8d_state_t    lead_st;
	logic            lead_has;
	logic [2:0]      lead_len;
	logic [7:0]      lead_mask;
	logic [CP_W-1:0] acc_n;
	logic [1:0]      taken_n;
	logic [1:0]      exp_n;
	logic [CP_W-1:0] floor_val;
	logic            bad;

	// Decode of the byte as if no sequence were open.
	always_comb begin
		lead_res  = '0;
		lead_st   = '0;
		lead_has  = 1'b1;
		lead_len  = SEQ_LEN2;
		lead_mask = 8'h1F;
		if (data_byte >= LEAD4_MIN) begin
			lead_len  = SEQ_LEN4;
			lead_mask = 8'h07;
		end else if (data_byte >= LEAD3_MIN) begin
			lead_len  = SEQ_LEN3;
			lead_mask = 8'h0F;
		end
		lead_res.byte_count = 3'd1;
		if (data_byte <= ASCII_MAX) begin
			lead_res.code_point = {{(CP_W-8){1'b0}}, data_byte};
		end else if (data_byte < LEAD2_MIN || data_byte >= LEAD_LIMIT) begin
			lead_res.is_error = 1'b1;
		end else if (end_of_data) begin
			lead_res.is_error = 1'b1;
		end else begin
			lead_has                     = 1'b0;
			lead_st.accumulated_bits     = {{(CP_W-8){1'b0}}, data_byte & lead_mask};
			lead_st.bytes_still_expected = 2'(lead_len - 3'd1);
			lead_st.bytes_taken          = 2'd1;
			lead_st.sequence_length      = lead_len;
		end
	end

	// Continuation path and range check of a completed sequence.
	always_comb begin
		acc_n   = {state_cur.accumulated_bits[CP_W-7:0], data_byte[5:0]};
		taken_n = state_cur.bytes_taken + 2'd1;
		exp_n   = state_cur.bytes_still_expected - 2'd1;
		case (state_cur.sequence_length)
			SEQ_LEN4: floor_val = FLOOR_LEN4;
			SEQ_LEN3: floor_val = FLOOR_LEN3;
			default:  floor_val = FLOOR_LEN2;
		endcase
		bad = (acc_n <= floor_val) || (acc_n >= SURROGATE_LO && acc_n <= SURROGATE_HI) ||
		      (acc_n > MAX_SCALAR);
	end

	always_comb begin
		state_nxt = state_cur;
		res0      = '0;
		res1      = '0;
		res_cnt   = 2'd0;
		if (state_cur.bytes_still_expected != 2'd0) begin
			if (data_byte[7:6] == CONT_TAG) begin
				if (exp_n == 2'd0) begin
					res0.code_point = bad ? '0 : acc_n;
					res0.is_error   = bad;
					res0.byte_count = state_cur.sequence_length;
					res_cnt         = 2'd1;
					state_nxt       = '0;
				end else if (end_of_data) begin
					res0.is_error   = 1'b1;
					res0.byte_count = {1'b0, taken_n};
					res_cnt         = 2'd1;
					state_nxt       = '0;
				end else begin
					state_nxt.accumulated_bits     = acc_n;
					state_nxt.bytes_still_expected = exp_n;
					state_nxt.bytes_taken          = taken_n;
				end
			end else begin
				// The broken sequence is reported, then the byte starts over.
				res0.is_error   = 1'b1;
				res0.byte_count = {1'b0, state_cur.bytes_taken};
				res1            = lead_res;
				res_cnt         = lead_has ? 2'd2 : 2'd1;
				state_nxt       = lead_st;
			end
		end else begin
			res0      = lead_res;
			res_cnt   = {1'b0, lead_has};
			state_nxt = lead_st;
		end
		if (res_cnt == 2'd1) begin
			res0.last_of_run = 1'b1;
		end
		if (res_cnt == 2'd2) begin
			res1.last_of_run = 1'b1;
		end
	end

endmodule

[rtl/core/utf8d_result_fifo.sv]
// Result queue that takes up to two results per cycle and delivers one.
`timescale 1ns / 1ps

module utf8d_result_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  utf8d_pkg::utf8d_result_t push0,
	input  utf8d_pkg::utf8d_result_t push1,
	input  logic [1:0]               push_cnt,
	input  logic                     pop,
	output utf8d_pkg::utf8d_result_t head,
	output logic                     not_empty,
	output logic                     room_for_two
);
	import utf8d_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utf8d_result_t   entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   wr_ptr_p1;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_p1    = ptr_inc(wr_ptr_q);
	assign head         = entries_q[rd_ptr_q];
	assign not_empty    = (count_q != '0);
	assign room_for_two = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entries_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entries_q[wr_ptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_cnt == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_cnt == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

[rtl/core/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder: bytes in, code points or error results out.
//
// One UTF-8 byte is taken per word on the slave side (tdata holds the byte, tlast marks
// the last byte of the stream) and decoded code points come out as words on the master
// side, one result per word. The block sustains one byte per cycle while the queue has
// room. A byte first lands in an input register; a single pass of shallow logic then
// checks it against the open sequence and writes its results into a small result queue,
// from which the master side takes one word per cycle while tready is high, so a result
// is offered only after passing through both. Most bytes give one result or none (a
// continuation byte in mid-sequence gives none). A byte that breaks an open sequence
// gives an error for the dropped bytes and then, unless it opens a new sequence, its own
// result; the extra result can hold up the slave side, as the queue drains one word per cycle.
// While results wait to be taken, the slave side goes on accepting bytes as long as the
// queue has room for two more results; beyond that one more byte can wait in the input
// register before tready drops. Sequences must use continuation bytes 10xxxxxx and must
// not be overlong, a surrogate or above 10FFFF; bytes 80-BF and F8-FF seen as a lead are
// errors at once. Every error result carries a zero code point and the number of bytes
// it covers, and tlast on the master side marks the final result caused by one input
// byte. Bytes with tlast set flush any unfinished sequence as an error.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit #(
	parameter int RESULT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_data
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [utf8d_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [20:0] code_point,
	                                                         // [21] is_error,
	                                                         // [24:22] byte_count, rest zero
	output logic        m_axis_tlast    // last_of_run
);
	import utf8d_pkg::*;

	// Input register: one byte waiting for the decode pass.
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// Open sequence, updated each time a byte is decoded.
	utf8d_state_t  seq_q;
	utf8d_state_t  seq_nxt;

	utf8d_result_t res0;
	utf8d_result_t res1;
	logic [1:0]    res_cnt;
	logic [1:0]    push_cnt;
	utf8d_result_t head;
	logic          room_for_two;
	logic          consume;

	// A byte is decoded only when the queue can take both of its possible results.
	assign consume       = valid_s1 && room_for_two;
	assign s_axis_tready = !valid_s1 || consume;
	assign push_cnt      = consume ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (consume) begin
			seq_q <= seq_nxt;
		end
	end

	utf8d_decode u_decode (
		.data_byte   (byte_s1),
		.end_of_data (last_s1),
		.state_cur   (seq_q),
		.state_nxt   (seq_nxt),
		.res0        (res0),
		.res1        (res1),
		.res_cnt     (res_cnt)
	);

	utf8d_result_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_result_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push0        (res0),
		.push1        (res1),
		.push_cnt     (push_cnt),
		.pop          (m_axis_tvalid && m_axis_tready),
		.head         (head),
		.not_empty    (m_axis_tvalid),
		.room_for_two (room_for_two)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - CP_W - 1 - COUNT_W){1'b0}},
	                       head.byte_count, head.is_error, head.code_point};
	assign m_axis_tlast = head.last_of_run;

endmodule

[rtl/core/utf8d_checker.sv]
// Port-level checker of the UTF-8 stream decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_unit_defines.svh"

module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	`UTF8D_ASSERT_STALL_HOLD(a_out_valid_hold, clk, arst_n, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "result word withdrawn while stalled")

	`UTF8D_ASSERT_STALL_HOLD(a_out_data_hold, clk, arst_n, m_axis_tvalid, m_axis_tready, {m_axis_tlast, m_axis_tdata}, "result word changed while stalled")

	// An error word never carries a code point.
	`UTF8D_ASSERT(a_error_zero_cp, clk, arst_n, m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[20:0] == 21'd0, "error word with nonzero code point")

	// A good word covers one to four bytes and holds a scalar value outside the surrogates.
	`UTF8D_ASSERT(a_good_word_range, clk, arst_n, m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tdata[24:22] != 3'd0 && m_axis_tdata[24:22] <= 3'd4 && m_axis_tdata[20:0] <= 21'h10FFFF && (m_axis_tdata[20:0] < 21'h00D800 || m_axis_tdata[20:0] > 21'h00DFFF), "good word out of range")

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_utf8d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
